/* hdl/tvce_pkg.sv */
// Shared types, constants and tables for the turtle vector command engine.
// Holds the command record passed front to back, the opcodes, the direction
// table and the quarter-wave sine ROM. No dependencies.
package tvce_pkg;

    // Stream payload widths
    localparam int VAL_W      = 16;
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int ANGLE_W    = 10;
    localparam int SCALE_W    = 15;
    localparam int IN_DATA_W  = 2 * VAL_W;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 6 * COORD_W + COLOR_W;
    localparam int OUT_USER_W = 1;

    // Datapath widths
    localparam int BASE_W = 32;
    localparam int COEF_W = 18;
    localparam int PROD_W = BASE_W + COEF_W;
    localparam int TRIG_W = 17;

    // Angle constants and reciprocal for the mod-360 reduction
    localparam int DEG_QUARTER = 90;
    localparam int DEG_HALF    = 180;
    localparam int DEG_3Q      = 270;
    localparam int DEG_FULL    = 360;
    localparam logic [15:0] RECIP_360   = 16'd46604;   // ceil(2^24 / 360)
    localparam int          RECIP_SHIFT = 24;
    localparam int          QUOT_W      = 7;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Opcodes on the input stream
    localparam logic [3:0] OP_STEP_FIRST = 4'd0;
    localparam logic [3:0] OP_STEP_LAST  = 4'd7;
    localparam logic [3:0] OP_MOVE       = 4'd8;
    localparam logic [3:0] OP_COLOR      = 4'd9;
    localparam logic [3:0] OP_SCALE      = 4'd10;
    localparam logic [3:0] OP_QUARTER    = 4'd11;
    localparam logic [3:0] OP_TURN       = 4'd12;
    localparam logic [3:0] OP_NO_DRAW    = 4'd13;
    localparam logic [3:0] OP_RETURN     = 4'd14;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_STEP,
        CMD_MOVE,
        CMD_COLOR,
        CMD_SCALE,
        CMD_QUARTER,
        CMD_TURN,
        CMD_NO_DRAW,
        CMD_RETURN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic signed [VAL_W-1:0] v1;
        logic                    r1;
        logic signed [VAL_W-1:0] v2;
        logic                    r2;
        logic signed [1:0]       dx;
        logic signed [1:0]       dy;
    } cmd_t;

    // Unit directions U,D,L,R,E,F,G,H; y grows downward
    localparam logic signed [1:0] DIR_DX [8] =
        '{2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
    localparam logic signed [1:0] DIR_DY [8] =
        '{-2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1};

    localparam logic signed [ANGLE_W-1:0] QUARTER_DEG [4] =
        '{10'sd0, 10'sd90, 10'sd180, 10'sd270};

    // Sine ROM, round(16384*sin(k deg)) for k = 0..90, built at elaboration
    // from a Q30 Taylor series.
    typedef logic [14:0] sin_rom_t [0:90];

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] SERIES_DIV [1:7] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    function automatic sin_rom_t build_sin_rom();
        sin_rom_t    rom;
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] t;
        for (int d = 0; d <= DEG_QUARTER; d++) begin
            x   = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
            sum = x;
            t   = x;
            for (int n = 1; n <= 7; n++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                t = t / SERIES_DIV[n];
                if ((n & 1) == 1)
                    sum = sum - t;
                else
                    sum = sum + t;
            end
            rom[d] = 15'((sum * 64'd16384 + (64'd1 << 29)) >> 30);
        end
        return rom;
    endfunction

    localparam sin_rom_t SIN_ROM = build_sin_rom();

    // Full-circle sine in Q2.14 for an angle already folded to 0..359
    function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [8:0] ang);
        logic [6:0]               idx;
        logic                     neg;
        logic signed [TRIG_W-1:0] mag;
        if (ang <= 9'(DEG_QUARTER)) begin
            idx = ang[6:0];
            neg = 1'b0;
        end else if (ang <= 9'(DEG_HALF)) begin
            idx = 7'(9'(DEG_HALF) - ang);
            neg = 1'b0;
        end else if (ang <= 9'(DEG_3Q)) begin
            idx = 7'(ang - 9'(DEG_HALF));
            neg = 1'b1;
        end else begin
            idx = 7'(9'(DEG_FULL) - ang);
            neg = 1'b1;
        end
        mag = $signed({2'b00, SIN_ROM[idx]});
        return neg ? -mag : mag;
    endfunction

endpackage

/* hdl/tvce_front.sv */
// Front end: input stream handshake and opcode classification.
// Depends on tvce_pkg; feeds tvce_cmd_queue.
module tvce_front
    import tvce_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,   // first_value, second_value
    input  logic [IN_USER_W-1:0] s_axis_tuser,   // operation[3:0], first_relative,
                                                 // second_relative
    input  logic                 queue_full,
    output logic                 push,
    output cmd_t                 push_cmd
);

    logic [3:0] op;
    cmd_kind_t  kind;

    assign op            = s_axis_tuser[3:0];
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    always_comb begin
        unique case (op) inside
            [OP_STEP_FIRST:OP_STEP_LAST]: kind = CMD_STEP;
            OP_MOVE:                      kind = CMD_MOVE;
            OP_COLOR:                     kind = CMD_COLOR;
            OP_SCALE:                     kind = CMD_SCALE;
            OP_QUARTER:                   kind = CMD_QUARTER;
            OP_TURN:                      kind = CMD_TURN;
            OP_NO_DRAW:                   kind = CMD_NO_DRAW;
            OP_RETURN:                    kind = CMD_RETURN;
            default:                      kind = CMD_NOP;
        endcase
    end

    always_comb begin
        push_cmd.kind = kind;
        push_cmd.v1   = $signed(s_axis_tdata[VAL_W-1:0]);
        push_cmd.r1   = s_axis_tuser[4];
        push_cmd.v2   = $signed(s_axis_tdata[2*VAL_W-1:VAL_W]);
        push_cmd.r2   = s_axis_tuser[5];
        push_cmd.dx   = DIR_DX[op[2:0]];
        push_cmd.dy   = DIR_DY[op[2:0]];
    end

endmodule

/* hdl/tvce_cmd_queue.sv */
// Short command queue between the front end and the execution back end.
// Depends on tvce_pkg.
module tvce_cmd_queue
    import tvce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue count exceeds depth");

endmodule

/* hdl/tvce_back.sv */
// Back end: four-step sequencer that executes one command, keeps the pen
// state and drives the result stream register. Depends on tvce_pkg.
module tvce_back
    import tvce_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128,
    parameter int FRAC_BITS     = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // line_x0, line_y0, line_x1, line_y1,
                                                 // line_color, pen_x_after, pen_y_after
    output logic [OUT_USER_W-1:0] m_axis_tuser   // drawn
);

    localparam int PW   = COORD_W + FRAC_BITS;
    localparam int SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int DW   = PROD_W + SH_L;
    localparam int SUMW = ((DW > PW) ? DW : PW) + 2;

    localparam logic signed [PW-1:0] PEN_X_RST = PW'(SCREEN_WIDTH) <<< (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] PEN_Y_RST = PW'(SCREEN_HEIGHT) <<< (FRAC_BITS - 1);
    localparam logic signed [PW-1:0] POS_HI    = PW'(32767) <<< FRAC_BITS;
    localparam logic signed [PW-1:0] POS_LO    = PW'(-32768) <<< FRAC_BITS;
    localparam logic [PW-1:0]        HALF      = PW'(1) << (FRAC_BITS - 1);
    localparam logic [DW-1:0]        RND       =
        (SH_R > 0) ? (DW'(1) << ((SH_R > 0) ? (SH_R - 1) : 0)) : '0;
    localparam logic signed [SUMW-1:0] SUM_ZERO = '0;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_APPLY, ST_WRITE} state_t;

    function automatic logic signed [PW-1:0] clamp_pos(input logic signed [SUMW-1:0] p);
        if (p > SUMW'(POS_HI))
            return POS_HI;
        else if (p < SUMW'(POS_LO))
            return POS_LO;
        else
            return PW'(p);
    endfunction

    // Half away from zero, low 16 bits
    function automatic logic [COORD_W-1:0] round_pos(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        q   = (mag + HALF) >> FRAC_BITS;
        return p[PW-1] ? COORD_W'(-q) : COORD_W'(q);
    endfunction

    // value*scale*coef (Q14) / 4 brought to FRAC_BITS fraction bits
    function automatic logic signed [SUMW-1:0] scale_delta(
        input logic signed [PROD_W-1:0] prod);
        logic [PROD_W-1:0] m;
        logic [DW-1:0]     r;
        m = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        r = ((DW'(m) + RND) >> SH_R) << SH_L;
        return prod[PROD_W-1] ? -SUMW'(r) : SUMW'(r);
    endfunction

    function automatic logic signed [COEF_W-1:0] dir_term(
        input logic signed [1:0]        dir,
        input logic signed [TRIG_W-1:0] v);
        case (dir)
            2'sd1:   return COEF_W'(v);
            -2'sd1:  return -COEF_W'(v);
            default: return '0;
        endcase
    endfunction

    state_t                      state_reg, state_next;
    cmd_t                        cmd_reg, cmd_next;
    logic signed [BASE_W-1:0]    base_reg, base_next;
    logic signed [COEF_W-1:0]    coef_x_reg, coef_x_next;
    logic signed [COEF_W-1:0]    coef_y_reg, coef_y_next;
    logic                        turn_neg_reg, turn_neg_next;
    logic [VAL_W-1:0]            turn_mag_reg, turn_mag_next;
    logic signed [PROD_W-1:0]    prod_x_reg, prod_x_next;
    logic signed [PROD_W-1:0]    prod_y_reg, prod_y_next;
    logic [QUOT_W-1:0]           quot_reg, quot_next;
    logic signed [PW-1:0]        new_x_reg, new_x_next;
    logic signed [PW-1:0]        new_y_reg, new_y_next;
    logic signed [ANGLE_W-1:0]   angle_new_reg, angle_new_next;
    logic signed [PW-1:0]        pen_x_reg, pen_x_next;
    logic signed [PW-1:0]        pen_y_reg, pen_y_next;
    logic signed [ANGLE_W-1:0]   axis_angle_reg, axis_angle_next;
    logic [SCALE_W-1:0]          step_scale_reg, step_scale_next;
    logic [COLOR_W-1:0]          pen_color_reg, pen_color_next;
    logic                        skip_drawing_reg, skip_drawing_next;
    logic                        return_after_reg, return_after_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_drawn_reg, out_drawn_next;
    logic [OUT_DATA_W-1:0]       out_data_reg, out_data_next;

    // Trig and prep (idle step)
    logic [8:0]                  sin_ang, cos_ang;
    logic signed [10:0]          cos_sum;
    logic signed [TRIG_W-1:0]    sin_v, cos_v;
    logic signed [VAL_W:0]       turn_sum;

    // Multiply step
    logic [31:0]                 recip_prod;

    // Apply step
    logic [VAL_W-1:0]            rem_full;
    logic signed [ANGLE_W-1:0]   turn_angle, qtr_angle;
    logic [1:0]                  qtr;
    logic signed [PW-1:0]        apply_x, apply_y;
    logic signed [ANGLE_W-1:0]   apply_angle;

    // Write step
    logic                        is_motion, out_free;
    logic signed [PW-1:0]        pen_x_after, pen_y_after;
    logic [COLOR_W-1:0]          color_after;

    assign cmd_pop       = (state_reg == ST_IDLE) && cmd_valid;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_drawn_reg;

    always_comb begin
        sin_ang = axis_angle_reg[ANGLE_W-1] ?
                  9'(axis_angle_reg + 10'(DEG_FULL)) : 9'(axis_angle_reg);
        cos_sum = 11'(axis_angle_reg) + 11'(DEG_QUARTER);
        if (cos_sum < 0)
            cos_ang = 9'(cos_sum + 11'(DEG_FULL));
        else if (cos_sum >= 11'(DEG_FULL))
            cos_ang = 9'(cos_sum - 11'(DEG_FULL));
        else
            cos_ang = 9'(cos_sum);
        sin_v    = sin_q14(sin_ang);
        cos_v    = sin_q14(cos_ang);
        turn_sum = 17'(axis_angle_reg) + 17'(cmd.v1);
    end

    assign recip_prod = turn_mag_reg * RECIP_360;

    // Remainder and quarter-turn angles
    always_comb begin
        rem_full   = turn_mag_reg - 16'(quot_reg) * 16'(DEG_FULL);
        turn_angle = turn_neg_reg ? -$signed({1'b0, rem_full[8:0]})
                                  :  $signed({1'b0, rem_full[8:0]});
        qtr        = cmd_reg.v1[VAL_W-1] ? 2'(2'd0 - cmd_reg.v1[1:0]) : cmd_reg.v1[1:0];
        qtr_angle  = cmd_reg.v1[VAL_W-1] ? -QUARTER_DEG[qtr] : QUARTER_DEG[qtr];
    end

    always_comb begin
        apply_x     = pen_x_reg;
        apply_y     = pen_y_reg;
        apply_angle = axis_angle_reg;
        unique case (cmd_reg.kind)
            CMD_STEP:
            begin
                apply_x = clamp_pos(SUMW'(pen_x_reg) + scale_delta(prod_x_reg));
                apply_y = clamp_pos(SUMW'(pen_y_reg) + scale_delta(prod_y_reg));
            end
            CMD_MOVE:
            begin
                apply_x = clamp_pos((cmd_reg.r1 ? SUMW'(pen_x_reg) : SUM_ZERO)
                                    + (SUMW'(cmd_reg.v1) <<< FRAC_BITS));
                apply_y = clamp_pos((cmd_reg.r2 ? SUMW'(pen_y_reg) : SUM_ZERO)
                                    + (SUMW'(cmd_reg.v2) <<< FRAC_BITS));
            end
            CMD_QUARTER: apply_angle = qtr_angle;
            CMD_TURN:    apply_angle = turn_angle;
            default:     apply_angle = axis_angle_reg;
        endcase
    end

    always_comb begin
        is_motion   = (cmd_reg.kind == CMD_STEP) || (cmd_reg.kind == CMD_MOVE);
        out_free    = !out_valid_reg || m_axis_tready;
        pen_x_after = (is_motion && !return_after_reg) ? new_x_reg : pen_x_reg;
        pen_y_after = (is_motion && !return_after_reg) ? new_y_reg : pen_y_reg;
        color_after = (cmd_reg.kind == CMD_COLOR) ? cmd_reg.v1[COLOR_W-1:0] : pen_color_reg;
    end

    always_comb begin
        state_next        = state_reg;
        cmd_next          = cmd_reg;
        base_next         = base_reg;
        coef_x_next       = coef_x_reg;
        coef_y_next       = coef_y_reg;
        turn_neg_next     = turn_neg_reg;
        turn_mag_next     = turn_mag_reg;
        prod_x_next       = prod_x_reg;
        prod_y_next       = prod_y_reg;
        quot_next         = quot_reg;
        new_x_next        = new_x_reg;
        new_y_next        = new_y_reg;
        angle_new_next    = angle_new_reg;
        pen_x_next        = pen_x_reg;
        pen_y_next        = pen_y_reg;
        axis_angle_next   = axis_angle_reg;
        step_scale_next   = step_scale_reg;
        pen_color_next    = pen_color_reg;
        skip_drawing_next = skip_drawing_reg;
        return_after_next = return_after_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_drawn_next    = out_drawn_reg;
        out_data_next     = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next      = cmd;
                    base_next     = cmd.v1 * $signed({1'b0, step_scale_reg});
                    coef_x_next   = dir_term(cmd.dx, cos_v) - dir_term(cmd.dy, sin_v);
                    coef_y_next   = dir_term(cmd.dx, sin_v) + dir_term(cmd.dy, cos_v);
                    turn_neg_next = turn_sum[VAL_W];
                    turn_mag_next = turn_sum[VAL_W] ? VAL_W'(-turn_sum) : VAL_W'(turn_sum);
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_x_next = base_reg * coef_x_reg;
                prod_y_next = base_reg * coef_y_reg;
                quot_next   = recip_prod[RECIP_SHIFT +: QUOT_W];
                state_next  = ST_APPLY;
            end
            ST_APPLY:
            begin
                new_x_next     = apply_x;
                new_y_next     = apply_y;
                angle_new_next = apply_angle;
                state_next     = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    pen_x_next      = pen_x_after;
                    pen_y_next      = pen_y_after;
                    axis_angle_next = angle_new_reg;
                    pen_color_next  = color_after;
                    if ((cmd_reg.kind == CMD_SCALE) && !cmd_reg.v1[VAL_W-1] && (cmd_reg.v1 != '0))
                        step_scale_next = cmd_reg.v1[SCALE_W-1:0];
                    if (is_motion)
                    begin
                        skip_drawing_next = 1'b0;
                        return_after_next = 1'b0;
                    end
                    else if (cmd_reg.kind == CMD_NO_DRAW)
                        skip_drawing_next = 1'b1;
                    else if (cmd_reg.kind == CMD_RETURN)
                        return_after_next = 1'b1;
                    out_valid_next = 1'b1;
                    out_drawn_next = is_motion && !skip_drawing_reg;
                    out_data_next  = {round_pos(pen_y_after), round_pos(pen_x_after),
                                      color_after,
                                      round_pos(new_y_reg), round_pos(new_x_reg),
                                      round_pos(pen_y_reg), round_pos(pen_x_reg)};
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cmd_reg          <= '0;
            base_reg         <= '0;
            coef_x_reg       <= '0;
            coef_y_reg       <= '0;
            turn_neg_reg     <= 1'b0;
            turn_mag_reg     <= '0;
            prod_x_reg       <= '0;
            prod_y_reg       <= '0;
            quot_reg         <= '0;
            new_x_reg        <= '0;
            new_y_reg        <= '0;
            angle_new_reg    <= '0;
            pen_x_reg        <= PEN_X_RST;
            pen_y_reg        <= PEN_Y_RST;
            axis_angle_reg   <= '0;
            step_scale_reg   <= SCALE_W'(4);
            pen_color_reg    <= COLOR_W'(1);
            skip_drawing_reg <= 1'b0;
            return_after_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_drawn_reg    <= 1'b0;
            out_data_reg     <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cmd_reg          <= cmd_next;
            base_reg         <= base_next;
            coef_x_reg       <= coef_x_next;
            coef_y_reg       <= coef_y_next;
            turn_neg_reg     <= turn_neg_next;
            turn_mag_reg     <= turn_mag_next;
            prod_x_reg       <= prod_x_next;
            prod_y_reg       <= prod_y_next;
            quot_reg         <= quot_next;
            new_x_reg        <= new_x_next;
            new_y_reg        <= new_y_next;
            angle_new_reg    <= angle_new_next;
            pen_x_reg        <= pen_x_next;
            pen_y_reg        <= pen_y_next;
            axis_angle_reg   <= axis_angle_next;
            step_scale_reg   <= step_scale_next;
            pen_color_reg    <= pen_color_next;
            skip_drawing_reg <= skip_drawing_next;
            return_after_reg <= return_after_next;
            out_valid_reg    <= out_valid_next;
            out_drawn_reg    <= out_drawn_next;
            out_data_reg     <= out_data_next;
        end
    end

    a_pen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pen_x_reg <= POS_HI) && (pen_x_reg >= POS_LO) &&
        (pen_y_reg <= POS_HI) && (pen_y_reg >= POS_LO))
        else $error("pen position outside saturation bounds");

    a_angle_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (axis_angle_reg <= 10'sd359) && (axis_angle_reg >= -10'sd359))
        else $error("axis angle outside -359..359");

    a_scale_positive: assert property (@(posedge clk) disable iff (!rst_n)
        step_scale_reg != '0)
        else $error("step scale became zero");

    a_pop_starts_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == ST_MUL))
        else $error("queue pop did not start a command");

    a_write_holds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WRITE) && out_valid_reg && !m_axis_tready)
        |=> (state_reg == ST_WRITE))
        else $error("result written over a pending output");

endmodule

/* hdl/turtle_vector_command_engine_top.sv */
// Top level of the turtle vector command engine: front end, command queue
// and execution back end. Depends on tvce_pkg, tvce_front, tvce_cmd_queue,
// tvce_back.
//
//   Channel   Dir  tdata                                    tuser
//   s_axis    in   [15:0] first_value, [31:16] second_value  [3:0] operation,
//                                                            [4] first_relative,
//                                                            [5] second_relative
//   m_axis    out  [15:0] line_x0, [31:16] line_y0,          [0] drawn
//                  [47:32] line_x1, [63:48] line_y1,
//                  [71:64] line_color, [87:72] pen_x_after,
//                  [103:88] pen_y_after
//
// Each command runs through the back-end steps in order: queue pop with trig
// lookup and value*scale multiply, rotation multiplies (and the mod-360
// reciprocal multiply), add and saturate, then result write. The write step
// holds while the output register still carries an untaken result; the front
// keeps accepting commands into the 2-entry queue meanwhile.
// Reset (rst_n low, async) puts the pen at screen center, angle 0, scale 4,
// color 1, prefixes clear, queue and output empty.
module turtle_vector_command_engine_top
    import tvce_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 128,
    parameter int FRAC_BITS     = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // first_value, second_value
    input  logic [IN_USER_W-1:0]  s_axis_tuser,   // operation[3:0], first_relative,
                                                  // second_relative
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // line_x0, line_y0, line_x1, line_y1,
                                                  // line_color, pen_x_after, pen_y_after
    output logic [OUT_USER_W-1:0] m_axis_tuser    // drawn
);

    // front -> queue
    logic push;
    cmd_t push_cmd;
    logic queue_full;

    // queue -> back
    logic head_valid;
    cmd_t head_cmd;
    logic cmd_pop;

    // Request handshake and opcode classification
    tvce_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    // Decouples input acceptance from execution
    tvce_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop        (cmd_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Pen state, arithmetic and result register
    tvce_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (head_valid),
        .cmd           (head_cmd),
        .cmd_pop       (cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* bench/turtle_vector_command_engine_top_tb.sv */
// Self-checking bench for turtle_vector_command_engine_top: drives decoded drawing
// commands on s_axis, predicts each segment result and checks every m_axis beat.
// Depends on tvce_pkg (opcodes, stream widths) and the engine RTL only.
`timescale 1ns / 1ps

module turtle_vector_command_engine_top_tb
    import tvce_pkg::*;
();

    localparam int SCREEN_W    = 128;
    localparam int SCREEN_H    = 128;
    localparam int FRAC        = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 240;
    localparam int DRAIN_TAIL  = 20;

    // Step opcodes by compass letter; y grows downward
    localparam logic [3:0] STEP_U = OP_STEP_FIRST;
    localparam logic [3:0] STEP_D = OP_STEP_FIRST + 4'd1;
    localparam logic [3:0] STEP_R = OP_STEP_FIRST + 4'd3;
    localparam logic [3:0] STEP_E = OP_STEP_FIRST + 4'd4;
    localparam logic [3:0] STEP_G = OP_STEP_FIRST + 4'd6;
    localparam logic [3:0] OP_UNUSED = 4'd15;

    localparam int UNIT_DX [8] = '{0, 0, -1, 1, 1, 1, -1, -1};
    localparam int UNIT_DY [8] = '{-1, 1, 0, 0, -1, 1, 1, -1};

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic signed [15:0] CORNER_ARGS [4] =
        '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};

    // One result beat, laid out as {tuser, tdata}
    typedef struct packed {
        logic               drawn;
        logic signed [15:0] after_y;
        logic signed [15:0] after_x;
        logic [7:0]         color;
        logic signed [15:0] y1;
        logic signed [15:0] x1;
        logic signed [15:0] y0;
        logic signed [15:0] x0;
    } segment_t;

    // Pen state tracker: mirrors the engine and queues the segment each command yields
    class turtle_pen_tracker;
        longint   pos_x;
        longint   pos_y;
        int       angle_deg;
        int       scale;
        logic [7:0] color;
        bit       skip_draw;
        bit       return_armed;
        int       sine_table [0:90];
        segment_t segment_q [$];
        int       errors;
        int       commands;
        int       drawn_count;
        int       clamps;

        function new();
            logic [63:0] x;
            logic [63:0] sum;
            logic [63:0] term;
            // quarter-wave table, Q30 odd series rounded to Q14
            for (int d = 0; d <= DEG_QUARTER; d++)
            begin
                x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
                sum  = x;
                term = x;
                for (int n = 1; n <= 7; n++)
                begin
                    term = (term * x) >> 30;
                    term = (term * x) >> 30;
                    term = term / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1)
                        sum = sum - term;
                    else
                        sum = sum + term;
                end
                sine_table[d] = int'((sum * 64'd16384 + (64'd1 << 29)) >> 30);
            end
            pos_x        = longint'(SCREEN_W) <<< (FRAC - 1);
            pos_y        = longint'(SCREEN_H) <<< (FRAC - 1);
            angle_deg    = 0;
            scale        = 4;
            color        = 8'd1;
            skip_draw    = 1'b0;
            return_armed = 1'b0;
            errors       = 0;
            commands     = 0;
            drawn_count  = 0;
            clamps       = 0;
        endfunction

        function int sine_q14(int a);
            a = a % DEG_FULL;
            if (a < 0)
                a = a + DEG_FULL;
            if (a <= DEG_QUARTER)
                return sine_table[a];
            if (a <= DEG_HALF)
                return sine_table[DEG_HALF - a];
            if (a <= DEG_3Q)
                return -sine_table[a - DEG_HALF];
            return -sine_table[DEG_FULL - a];
        endfunction

        function longint clamp_pos(longint p);
            longint hi;
            longint lo;
            hi = longint'(32767) <<< FRAC;
            lo = longint'(-32768) <<< FRAC;
            if (p > hi || p < lo)
                clamps++;
            return p > hi ? hi : (p < lo ? lo : p);
        endfunction

        // half away from zero, keep the low 16 bits
        function logic [15:0] round_pos(longint p);
            longint half;
            longint r;
            half = longint'(1) <<< (FRAC - 1);
            if (p >= 0)
                r = (p + half) >>> FRAC;
            else
                r = -((-p + half) >>> FRAC);
            return r[15:0];
        endfunction

        function int pending();
            return segment_q.size();
        endfunction

        function void note_command(logic [3:0] op, logic signed [15:0] a, logic ra,
                                   logic signed [15:0] b, logic rb);
            longint   old_x;
            longint   old_y;
            longint   new_x;
            longint   new_y;
            longint   base;
            int       cos_v;
            int       sin_v;
            int       rot_x;
            int       rot_y;
            bit       motion;
            segment_t seg;
            old_x  = pos_x;
            old_y  = pos_y;
            new_x  = old_x;
            new_y  = old_y;
            motion = 1'b0;
            commands++;
            case (op)
                OP_MOVE:
                begin
                    new_x  = clamp_pos((ra ? old_x : 64'sd0) + (longint'(a) <<< FRAC));
                    new_y  = clamp_pos((rb ? old_y : 64'sd0) + (longint'(b) <<< FRAC));
                    motion = 1'b1;
                end
                OP_COLOR:   color = a[7:0];
                OP_SCALE:   if (a > 0) scale = a;
                OP_QUARTER: angle_deg = (int'(a) * DEG_QUARTER) % DEG_FULL;
                OP_TURN:    angle_deg = (angle_deg + int'(a)) % DEG_FULL;
                OP_NO_DRAW: skip_draw = 1'b1;
                OP_RETURN:  return_armed = 1'b1;
                default:
                    if (op <= OP_STEP_LAST)
                    begin
                        // value*scale times rotated unit vector in Q14 lands in Q16.16
                        cos_v  = sine_q14(angle_deg + DEG_QUARTER);
                        sin_v  = sine_q14(angle_deg);
                        rot_x  = UNIT_DX[op] * cos_v - UNIT_DY[op] * sin_v;
                        rot_y  = UNIT_DX[op] * sin_v + UNIT_DY[op] * cos_v;
                        base   = longint'(a) * scale;
                        new_x  = clamp_pos(old_x + ((base * rot_x) <<< (FRAC - 16)));
                        new_y  = clamp_pos(old_y + ((base * rot_y) <<< (FRAC - 16)));
                        motion = 1'b1;
                    end
            endcase
            seg.drawn = 1'b0;
            if (motion)
            begin
                seg.drawn = !skip_draw;
                if (!return_armed)
                begin
                    pos_x = new_x;
                    pos_y = new_y;
                end
                skip_draw    = 1'b0;
                return_armed = 1'b0;
            end
            if (seg.drawn)
                drawn_count++;
            seg.x0      = round_pos(old_x);
            seg.y0      = round_pos(old_y);
            seg.x1      = round_pos(new_x);
            seg.y1      = round_pos(new_y);
            seg.color   = color;
            seg.after_x = round_pos(pos_x);
            seg.after_y = round_pos(pos_y);
            segment_q.push_back(seg);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
            end
        endfunction

        function void check_segment(segment_t got);
            segment_t want;
            if (segment_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none got %h", $time, got);
                return;
            end
            want = segment_q.pop_front();
            compare_field("drawn", want.drawn, got.drawn);
            compare_field("line_x0", want.x0, got.x0);
            compare_field("line_y0", want.y0, got.y0);
            compare_field("line_x1", want.x1, got.x1);
            compare_field("line_y1", want.y1, got.y1);
            compare_field("line_color", want.color, got.color);
            compare_field("pen_x_after", want.after_x, got.after_x);
            compare_field("pen_y_after", want.after_y, got.after_y);
        endfunction
    endclass

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // first_value, second_value
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;   // operation[3:0], first_relative,
                                                 // second_relative
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // line_x0, line_y0, line_x1, line_y1,
                                                 // line_color, pen_x_after, pen_y_after
    logic [OUT_USER_W-1:0] m_axis_tuser;         // drawn

    turtle_pen_tracker pen;
    int   send_idle   = 0;     // percent of cycles the sender sits idle
    int   recv_stall  = 0;     // percent of cycles the receiver stalls
    int   cycle_count = 0;
    logic hold_active = 1'b0;
    event hold_trigger;

    turtle_vector_command_engine_top #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H),
        .FRAC_BITS     (FRAC)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, forced low during a long hold
    always @(posedge clk)
        m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall);

    // Long output hold, counted here so the sender keeps pushing meanwhile
    initial
    begin
        forever
        begin
            @(hold_trigger);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // Results are checked before the same edge's request is noted; both are
    // sampled on pre-edge values, so the order is only bookkeeping.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                pen.check_segment(segment_t'({m_axis_tuser, m_axis_tdata}));
            if (s_axis_tvalid && s_axis_tready)
                pen.note_command(s_axis_tuser[3:0], s_axis_tdata[15:0], s_axis_tuser[4],
                                 s_axis_tdata[31:16], s_axis_tuser[5]);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pen.pending());
            $display("[turtle_vector_command_engine_top] ERROR");
            $finish;
        end
    end

    // One request; tvalid stays high into the next call unless a gap is rolled
    task automatic send_command(input logic [3:0] op, input logic signed [15:0] a,
                                input logic ra, input logic signed [15:0] b,
                                input logic rb);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= {rb, ra, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pen.pending() != 0);
    endtask

    function automatic logic signed [15:0] random_arg(input int lo, input int hi);
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return CORNER_ARGS[$urandom_range(3)];
            default: return 16'(lo + int'($urandom_range(hi - lo)));
        endcase
    endfunction

    // Mostly steps and moves with small values; prefixes land before motion
    // often enough, full-range values drive the clamps.
    task automatic random_command();
        logic [3:0]         op;
        logic signed [15:0] a;
        logic signed [15:0] b;
        int                 pick;
        pick = $urandom_range(99);
        b    = 16'($urandom);
        a    = 16'($urandom);
        if (pick < 40)
        begin
            op = OP_STEP_FIRST + 4'($urandom_range(7));
            a  = random_arg(-12, 12);
        end
        else if (pick < 55)
        begin
            op = OP_MOVE;
            a  = random_arg(-10, 140);
            b  = random_arg(-10, 140);
        end
        else if (pick < 61)
            op = OP_COLOR;
        else if (pick < 69)
        begin
            op = OP_SCALE;
            a  = random_arg(-2, 8);
        end
        else if (pick < 74)
        begin
            op = OP_QUARTER;
            a  = random_arg(-9, 9);
        end
        else if (pick < 83)
        begin
            op = OP_TURN;
            a  = random_arg(-400, 400);
        end
        else if (pick < 90)
            op = OP_NO_DRAW;
        else if (pick < 97)
            op = OP_RETURN;
        else
            op = OP_UNUSED;
        send_command(op, a, 1'($urandom), b, 1'($urandom));
    endtask

    initial
    begin
        pen = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: all eight steps, rotation, scale limits, clamps, prefixes
        for (int d = 0; d <= 7; d++)
            send_command(OP_STEP_FIRST + 4'(d), 16'sd10, 1'b0, 16'sd0, 1'b0);
        send_command(OP_TURN, 16'sd45, 1'b0, 16'sd0, 1'b0);
        send_command(STEP_E, 16'sd7, 1'b0, 16'sd0, 1'b0);
        send_command(OP_QUARTER, -16'sd3, 1'b0, 16'sd0, 1'b0);
        send_command(STEP_U, 16'sd5, 1'b0, 16'sd0, 1'b0);
        send_command(OP_COLOR, -16'sd1, 1'b0, 16'sd0, 1'b0);
        send_command(OP_SCALE, 16'sd0, 1'b0, 16'sd0, 1'b0);
        send_command(OP_SCALE, 16'sh7FFF, 1'b0, 16'sd0, 1'b0);
        send_command(STEP_R, 16'sh7FFF, 1'b0, 16'sd0, 1'b0);
        send_command(STEP_G, 16'sh8000, 1'b1, 16'sh7FFF, 1'b1);
        send_command(OP_MOVE, 16'sh8000, 1'b0, 16'sh8000, 1'b0);
        send_command(OP_MOVE, 16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1);
        send_command(OP_NO_DRAW, 16'sd0, 1'b0, 16'sd0, 1'b0);
        send_command(STEP_D, 16'sd3, 1'b0, 16'sd0, 1'b0);
        send_command(OP_RETURN, 16'sd0, 1'b0, 16'sd0, 1'b0);
        send_command(OP_NO_DRAW, 16'sd0, 1'b0, 16'sd0, 1'b0);
        send_command(OP_MOVE, 16'sd10, 1'b0, 16'sd20, 1'b0);
        send_command(OP_UNUSED, 16'shFFFF, 1'b1, 16'shFFFF, 1'b1);
        wait_drained();

        // Output held off while requests keep coming: queue fills, input stalls
        -> hold_trigger;
        for (int i = 0; i < 30; i++)
            random_command();
        wait_drained();

        // Random phases: free flowing, sparse sender, slow receiver, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 65; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 65; end
                default: begin send_idle = 28; recv_stall = 28; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_command();
            wait_drained();
        end

        // Catch any stray beat after the last expected one
        repeat (DRAIN_TAIL) @(posedge clk);
        $display("Covered %0d commands, %0d drawn segments, %0d clamped coordinates,",
                 pen.commands, pen.drawn_count, pen.clamps);
        $display("over four sender/receiver mixes plus a long output hold.");
        if (pen.errors == 0 && pen.pending() == 0)
            $display("[turtle_vector_command_engine_top] OK");
        else
            $display("[turtle_vector_command_engine_top] ERROR");
        $finish;
    end

endmodule
